### rtl/mesd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesd_pkg
// Shared types, command / grant / kind codes and sizes for the MESI sharer
// directory.
// ----------------------------------------------------------------------------
package mesd_pkg;

  localparam int NUM_CHILDREN = 16;
  localparam int NUM_LINES    = 1024;
  localparam int LINE_W       = 10;
  localparam int CHILD_W      = 4;
  localparam int CMD_W        = 4;
  localparam int GRANT_W      = 3;
  localparam int KIND_W       = 2;

  localparam logic [CMD_W-1:0] CMD_GETS    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_GETX    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PUTS    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_PUTX    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAN   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAN_S = 4'd5;
  localparam logic [CMD_W-1:0] CMD_EVICT   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_INVX    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_INV     = 4'd8;
  localparam logic [CMD_W-1:0] CMD_FWD     = 4'd9;

  localparam logic [GRANT_W-1:0] GRANT_NONE = 3'd0;
  localparam logic [GRANT_W-1:0] GRANT_I    = 3'd1;
  localparam logic [GRANT_W-1:0] GRANT_S    = 3'd2;
  localparam logic [GRANT_W-1:0] GRANT_E    = 3'd3;
  localparam logic [GRANT_W-1:0] GRANT_M    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INV  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [LINE_W-1:0]  line_index;
    logic [CHILD_W-1:0] child_id;
    logic               have_exclusive;
    logic               io_requester;
    logic               flag_pkt_in;
    logic               flag_pkt_out;
    logic               flag_no_excl;
    logic               flag_keep_excl;
  } req_t;

  typedef struct packed {
    logic [GRANT_W-1:0]      child_grant;
    logic [NUM_CHILDREN-1:0] inval_mask;
    logic [KIND_W-1:0]       inval_kind;
  } resp_t;

  // one directory entry; the sharer count is the population of the mask
  typedef struct packed {
    logic                    excl;
    logic [NUM_CHILDREN-1:0] sharers;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/mesd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mesd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/mesd_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesd_update
// Next directory entry and response for one request, given the current entry.
// ----------------------------------------------------------------------------
module mesd_update (
  input  mesd_pkg::req_t   req,
  input  mesd_pkg::entry_t cur,
  output mesd_pkg::entry_t nxt,
  output mesd_pkg::resp_t  resp
);

  logic [mesd_pkg::NUM_CHILDREN-1:0] cbit;
  logic [mesd_pkg::NUM_CHILDREN-1:0] rest;
  logic                              excl_cur;
  logic                              excl_rest;
  logic                              skip;

  function automatic logic one_bit(input logic [mesd_pkg::NUM_CHILDREN-1:0] v);
    return (v != '0) && ((v & (v - 1'b1)) == '0);
  endfunction

  assign cbit      = (mesd_pkg::NUM_CHILDREN)'(1) << req.child_id;
  assign rest      = cur.sharers & ~cbit;
  assign excl_cur  = cur.excl && one_bit(cur.sharers);
  assign excl_rest = cur.excl && one_bit(rest);
  assign skip      = (req.flag_pkt_in && req.io_requester) || req.flag_pkt_out;

  always_comb begin
    nxt  = cur;
    resp = '0;
    unique case (req.cmd)
      mesd_pkg::CMD_GETS: begin
        if (!req.flag_pkt_out && cur.sharers == '0 && req.have_exclusive &&
            !req.flag_no_excl) begin
          nxt.excl         = 1'b1;
          nxt.sharers      = cbit;
          resp.child_grant = mesd_pkg::GRANT_E;
        end else begin
          if (excl_cur) begin
            resp.inval_mask = cur.sharers;
            resp.inval_kind = mesd_pkg::KIND_DOWN;
            nxt.excl        = 1'b0;
          end
          if (!req.flag_pkt_out) begin
            nxt.sharers      = cur.sharers | cbit;
            nxt.excl         = 1'b0;
            resp.child_grant = mesd_pkg::GRANT_S;
          end
        end
      end
      mesd_pkg::CMD_GETX: begin
        // skipped requests leave the requester in the mask before invalidation
        if ((skip ? cur.sharers : rest) != '0) begin
          resp.inval_mask = skip ? cur.sharers : rest;
          resp.inval_kind = mesd_pkg::KIND_INV;
        end
        nxt.excl    = !req.flag_pkt_out;
        nxt.sharers = skip ? '0 : cbit;
        if (!skip) begin
          resp.child_grant = mesd_pkg::GRANT_M;
        end
      end
      mesd_pkg::CMD_PUTS: begin
        nxt.sharers      = rest;
        resp.child_grant = mesd_pkg::GRANT_I;
      end
      mesd_pkg::CMD_PUTX: begin
        if (req.flag_keep_excl) begin
          resp.child_grant = mesd_pkg::GRANT_E;
        end else begin
          nxt.sharers      = rest;
          resp.child_grant = mesd_pkg::GRANT_I;
        end
      end
      mesd_pkg::CMD_CLEAN: begin
        if (rest != '0) begin
          resp.inval_mask = rest;
          resp.inval_kind = mesd_pkg::KIND_INV;
        end
        nxt = '0;
      end
      mesd_pkg::CMD_CLEAN_S: begin
        nxt.sharers = rest;
        if (excl_rest) begin
          resp.inval_mask = rest;
          resp.inval_kind = mesd_pkg::KIND_DOWN;
          nxt.excl        = 1'b0;
        end
        if ((cur.sharers & cbit) != '0) begin
          nxt.sharers      = rest | cbit;
          nxt.excl         = 1'b0;
          resp.child_grant = mesd_pkg::GRANT_S;
        end
      end
      mesd_pkg::CMD_EVICT, mesd_pkg::CMD_INV: begin
        if (cur.sharers != '0) begin
          resp.inval_mask = cur.sharers;
          resp.inval_kind = mesd_pkg::KIND_INV;
          nxt.sharers     = '0;
        end
      end
      mesd_pkg::CMD_INVX: begin
        if (excl_cur) begin
          resp.inval_mask = cur.sharers;
          resp.inval_kind = mesd_pkg::KIND_DOWN;
          nxt.excl        = 1'b0;
        end
      end
      default: begin
        // forward and unused codes leave everything alone
        nxt  = cur;
        resp = '0;
      end
    endcase
  end

endmodule

### rtl/mesi_sharer_directory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesi_sharer_directory
// Inclusive MESI directory: per-line sharer mask and exclusive bit, one
// request in, one grant / invalidation response out.
// ----------------------------------------------------------------------------
// usage:
//   in_valid / in_stall / in_data carry request beats (req_t); out_valid /
//   out_stall / out_data carry response beats (resp_t), exactly one per request.
//   a request beat is accepted at an edge with in_valid high and in_stall low.
//   the accepted beat's line is read from the directory RAM at that edge; once
//   the update stage can pass its request on, the entry is updated and the
//   response lands in the output register, which raises out_valid.
//   while out_stall is low, one request per cycle is sustained, back-to-back
//   hits to the same line included: the last entry written is forwarded past
//   the RAM read port. after reset the directory RAM is cleared one line per
//   cycle, all 1024 lines, with in_stall held high.
//   while out_stall holds a response, the update stage holds its request and
//   in_stall rises once that stage is also full; nothing is dropped.
// ----------------------------------------------------------------------------
module mesi_sharer_directory (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mesd_pkg::req_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mesd_pkg::resp_t  out_data
);

  localparam logic [mesd_pkg::LINE_W-1:0] LAST_LINE =
    (mesd_pkg::LINE_W)'(mesd_pkg::NUM_LINES - 1);

  logic                           clr_busy_r;
  logic [mesd_pkg::LINE_W-1:0]    clr_addr_r;
  logic                           s1_valid_r;
  mesd_pkg::req_t                 s1_req_r;
  logic                           fwd_valid_r;
  logic [mesd_pkg::LINE_W-1:0]    fwd_addr_r;
  mesd_pkg::entry_t               fwd_entry_r;
  logic                           out_valid_r;
  mesd_pkg::resp_t                out_data_r;

  logic                           out_free;
  logic                           s1_fire;
  logic                           in_fire;
  logic                           ram_we;
  logic [mesd_pkg::LINE_W-1:0]    ram_waddr;
  mesd_pkg::entry_t               ram_wdata;
  mesd_pkg::entry_t               ram_rdata;
  mesd_pkg::entry_t               cur_entry;
  mesd_pkg::entry_t               new_entry;
  mesd_pkg::resp_t                new_resp;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = clr_busy_r || (s1_valid_r && !out_free);
  assign in_fire  = in_valid && !in_stall;

  assign ram_we    = clr_busy_r || s1_fire;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_req_r.line_index;
  assign ram_wdata = clr_busy_r ? '0 : new_entry;

  mesd_ram #(
    .WIDTH (mesd_pkg::ENTRY_W),
    .DEPTH (mesd_pkg::NUM_LINES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_data.line_index),
    .rdata (ram_rdata)
  );

  // a read issued on the edge of a write to the same line returns old data
  assign cur_entry = (fwd_valid_r && fwd_addr_r == s1_req_r.line_index) ?
                     fwd_entry_r : ram_rdata;

  mesd_update u_update (
    .req  (s1_req_r),
    .cur  (cur_entry),
    .nxt  (new_entry),
    .resp (new_resp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_LINE) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        fwd_valid_r <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_data;
    end
    if (s1_fire) begin
      fwd_addr_r  <= s1_req_r.line_index;
      fwd_entry_r <= new_entry;
      out_data_r  <= new_resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_kind_matches_mask : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.inval_kind == mesd_pkg::KIND_NONE) ==
                     (out_data_r.inval_mask == '0)))
    else $error("inval_kind and inval_mask disagree");

  a_clear_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_valid_r && !out_valid_r && ram_wdata == '0))
    else $error("request in flight during directory clear");

  a_owner_single : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && new_resp.child_grant == mesd_pkg::GRANT_M) |->
      ($onehot(new_entry.sharers) && new_entry.excl))
    else $error("modified grant without a single exclusive owner");

  a_resp_follows_req : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("response without a request in the update stage");

endmodule
